[hdl/ivwa_pkg.sv]
// Shared types and constants for the inverse-variance weighted average block.
package ivwa_pkg;

  typedef struct packed {
    logic [1:0]         component;
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    logic [31:0]        value_err;
    logic               last_site;
  } ivwa_in_t;

  typedef struct packed {
    logic [1:0]         out_component;
    logic signed [31:0] avg_re;
    logic signed [31:0] avg_im;
    logic [31:0]        avg_err;
  } ivwa_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ivwa_unit_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_RE,
    S_SQ_IM,
    S_MAG,
    S_MAG_WAIT,
    S_FLOOR_MUL,
    S_FLOOR,
    S_ERR_MUL,
    S_W_DIV,
    S_W_WAIT,
    S_WR_HI,
    S_WR_LO,
    S_WR_P,
    S_WI_LO,
    S_WI_P,
    S_WI_ACC,
    S_CHK,
    S_T_DIV,
    S_T_WAIT,
    S_T_SQRT,
    S_T_SQRT_WAIT,
    S_MRE_DIV,
    S_MRE_WAIT,
    S_MIM_DIV,
    S_MIM_WAIT,
    S_OUT
  } ivwa_state_t;

  // register indexes (byte address / 4)
  localparam logic REG_ERROR_FLOOR  = 1'b0;
  localparam logic REG_ABSOLUTE_MIN = 1'b1;

  localparam logic [15:0] ERROR_FLOOR_RST  = 16'd1311;
  localparam logic [19:0] ABSOLUTE_MIN_RST = 20'd105;

endpackage

[hdl/ivwa_div.sv]
// Iterative restoring divider, one quotient bit per cycle, saturating.
module ivwa_div #(
  parameter int CNT_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [63:0]               num,
  input  logic [CNT_W-1:0]          nbits,
  input  logic [63:0]               den,
  input  logic [63:0]               lim,
  output ivwa_pkg::ivwa_unit_stat_t stat,
  output logic [63:0]               quot
);

  logic [63:0]      num_r, rem_r, den_r, lim_r, q_r;
  logic             sat_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [63:0] r_sh, rem_nxt, q_nxt, q2;
  logic        ge, sat_nxt;

  always_comb begin
    r_sh    = {rem_r[62:0], num_r[63]};
    ge      = rem_r[63] || (r_sh >= den_r);
    rem_nxt = ge ? (r_sh - den_r) : r_sh;
    q2      = {q_r[62:0], ge};
    q_nxt   = q_r;
    sat_nxt = sat_r;
    if (!sat_r) begin
      if (q_r > (lim_r >> 1)) begin
        sat_nxt = 1'b1;
      end else begin
        q_nxt = q2;
        if (q2 > lim_r) sat_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= nbits;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      den_r <= den;
      lim_r <= lim;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[62:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    stat.busy = (cnt_r != '0);
    stat.done = done_r;
    quot      = sat_r ? lim_r : q_r;
  end

endmodule

[hdl/ivwa_isqrt.sv]
// Iterative integer square root of a 64-bit value, one result bit per cycle.
module ivwa_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [63:0]               x,
  output ivwa_pkg::ivwa_unit_stat_t stat,
  output logic [31:0]               root
);

  logic [63:0] x_r, r_r, b_r;
  logic        done_r;
  logic [63:0] rb;
  logic        ge;

  always_comb begin
    rb = r_r + b_r;
    ge = (x_r >= rb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        b_r <= 64'd1 << 62;
      end else if (b_r != '0) begin
        b_r <= b_r >> 2;
        if (b_r == 64'd1) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      r_r <= '0;
    end else if (b_r != '0) begin
      x_r <= ge ? (x_r - rb) : x_r;
      r_r <= ge ? ((r_r >> 1) + b_r) : (r_r >> 1);
    end
  end

  always_comb begin
    stat.busy = (b_r != '0);
    stat.done = done_r;
    root      = r_r[31:0];
  end

endmodule

[hdl/inverse_variance_weighted_average.sv]
// Top level: inverse-variance weighted complex average with error floor.
// One input transaction is taken at a time; in_stall stays high while it is
// worked on. A 64-bit square root gives the magnitude, a shared 32x32
// multiplier forms the squares and products, and a one-bit-per-cycle divider
// forms the weight from 1+3*FRAC_BITS quotient bits; once the item is done,
// in_stall drops and the next transaction can be taken. An item marked last
// adds, if its bank holds any weight, a reciprocal divide, a root and two
// divides of 64+FRAC_BITS bits for the means, plus any wait for the output
// register to free up. The next transaction is taken while a result waits in
// the output register. Reset clears all banks at once.
module inverse_variance_weighted_average #(
  parameter int NUM_COMPONENTS = 4,
  parameter int FRAC_BITS      = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ivwa_pkg::ivwa_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ivwa_pkg::ivwa_out_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int K       = 32 - FRAC_BITS;
  localparam int DIV_CNT = 64 + 3 * FRAC_BITS;
  localparam int CNT_W   = $clog2(DIV_CNT + 1);
  localparam int IDX_W   = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam logic [CNT_W-1:0] W_BITS = CNT_W'(1 + 3 * FRAC_BITS);
  localparam logic [CNT_W-1:0] M_BITS = CNT_W'(64 + FRAC_BITS);
  localparam logic [63:0] WEIGHT_MAX = (64'd1 << 62) - 64'd1;
  localparam logic [63:0] INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HI_LIM     = INT64_MAX >> K;
  localparam logic [63:0] ONE_TOP    = 64'h8000_0000_0000_0000;

  ivwa_pkg::ivwa_state_t state_r, state_nxt;

  logic [15:0] error_floor_r;
  logic [19:0] absolute_min_r;

  logic [1:0]         comp_r;
  logic               last_r;
  logic signed [31:0] re_r, im_r;
  logic [31:0]        err_r, mag_r;
  logic [63:0]        sq_r, mul_r, hi_r, w_r;
  logic signed [63:0] wv_r;
  logic [31:0]        avg_re_r, avg_im_r, avg_err_r;
  logic               out_valid_r;
  ivwa_pkg::ivwa_out_t out_data_r;

  logic signed [63:0] swre_r [NUM_COMPONENTS];
  logic signed [63:0] swim_r [NUM_COMPONENTS];
  logic [63:0]        sw_r   [NUM_COMPONENTS];

  logic [IDX_W-1:0] idx;
  logic             in_ok, accept, out_load;
  logic [31:0]      are, aim, mul_a, mul_b;
  logic             div_start, sq_start;
  logic [63:0]      div_num, div_den, div_lim, div_quot, sq_x;
  logic [CNT_W-1:0] div_bits;
  logic [31:0]      sq_root;
  ivwa_pkg::ivwa_unit_stat_t div_stat, sq_stat;

  logic [63:0]        wsum, wp;
  logic               wneg;
  logic signed [63:0] wv_nxt;
  logic [31:0]        fl, fm, eff;
  logic [63:0]        abs_sre, abs_sim;
  logic               cfg_wr;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? {1'b1, 63'd0} : INT64_MAX;
    end else begin
      sat_add = s;
    end
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  assign idx      = IDX_W'(comp_r);
  assign in_ok    = 32'(in_data.component) < NUM_COMPONENTS;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ivwa_pkg::S_IDLE);
  assign out_load = (state_r == ivwa_pkg::S_OUT) && (!out_valid_r || !out_stall);
  assign are      = re_r[31] ? (~re_r + 32'd1) : re_r;
  assign aim      = im_r[31] ? (~im_r + 32'd1) : im_r;
  assign abs_sre  = abs64(swre_r[idx]);
  assign abs_sim  = abs64(swim_r[idx]);

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_floor_r  <= ivwa_pkg::ERROR_FLOOR_RST;
      absolute_min_r <= ivwa_pkg::ABSOLUTE_MIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ivwa_pkg::REG_ERROR_FLOOR:  error_floor_r  <= cfg_pwdata[15:0];
        ivwa_pkg::REG_ABSOLUTE_MIN: absolute_min_r <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ivwa_pkg::REG_ERROR_FLOOR:  cfg_prdata = {16'd0, error_floor_r};
      ivwa_pkg::REG_ABSOLUTE_MIN: cfg_prdata = {12'd0, absolute_min_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------- shared units ----------------
  ivwa_div #(.CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .nbits (div_bits),
    .den   (div_den),
    .lim   (div_lim),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  ivwa_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    mul_r <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ivwa_pkg::S_IDLE:        if (accept && in_ok) state_nxt = ivwa_pkg::S_SQ_RE;
      ivwa_pkg::S_SQ_RE:       state_nxt = ivwa_pkg::S_SQ_IM;
      ivwa_pkg::S_SQ_IM:       state_nxt = ivwa_pkg::S_MAG;
      ivwa_pkg::S_MAG:         state_nxt = ivwa_pkg::S_MAG_WAIT;
      ivwa_pkg::S_MAG_WAIT:    if (sq_stat.done) state_nxt = ivwa_pkg::S_FLOOR_MUL;
      ivwa_pkg::S_FLOOR_MUL:   state_nxt = ivwa_pkg::S_FLOOR;
      ivwa_pkg::S_FLOOR:       state_nxt = ivwa_pkg::S_ERR_MUL;
      ivwa_pkg::S_ERR_MUL:     state_nxt = ivwa_pkg::S_W_DIV;
      ivwa_pkg::S_W_DIV:       state_nxt = ivwa_pkg::S_W_WAIT;
      ivwa_pkg::S_W_WAIT:      if (div_stat.done) state_nxt = ivwa_pkg::S_WR_HI;
      ivwa_pkg::S_WR_HI:       state_nxt = ivwa_pkg::S_WR_LO;
      ivwa_pkg::S_WR_LO:       state_nxt = ivwa_pkg::S_WR_P;
      ivwa_pkg::S_WR_P:        state_nxt = ivwa_pkg::S_WI_LO;
      ivwa_pkg::S_WI_LO:       state_nxt = ivwa_pkg::S_WI_P;
      ivwa_pkg::S_WI_P:        state_nxt = ivwa_pkg::S_WI_ACC;
      ivwa_pkg::S_WI_ACC:      state_nxt = ivwa_pkg::S_CHK;
      ivwa_pkg::S_CHK: begin
        priority if (!last_r)            state_nxt = ivwa_pkg::S_IDLE;
        else if (sw_r[idx] == 64'd0)     state_nxt = ivwa_pkg::S_OUT;
        else                             state_nxt = ivwa_pkg::S_T_DIV;
      end
      ivwa_pkg::S_T_DIV:       state_nxt = ivwa_pkg::S_T_WAIT;
      ivwa_pkg::S_T_WAIT:      if (div_stat.done) state_nxt = ivwa_pkg::S_T_SQRT;
      ivwa_pkg::S_T_SQRT:      state_nxt = ivwa_pkg::S_T_SQRT_WAIT;
      ivwa_pkg::S_T_SQRT_WAIT: if (sq_stat.done) state_nxt = ivwa_pkg::S_MRE_DIV;
      ivwa_pkg::S_MRE_DIV:     state_nxt = ivwa_pkg::S_MRE_WAIT;
      ivwa_pkg::S_MRE_WAIT:    if (div_stat.done) state_nxt = ivwa_pkg::S_MIM_DIV;
      ivwa_pkg::S_MIM_DIV:     state_nxt = ivwa_pkg::S_MIM_WAIT;
      ivwa_pkg::S_MIM_WAIT:    if (div_stat.done) state_nxt = ivwa_pkg::S_OUT;
      ivwa_pkg::S_OUT:         if (out_load) state_nxt = ivwa_pkg::S_IDLE;
      default:                 state_nxt = ivwa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ivwa_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- unit controls ----------------
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = ONE_TOP;
    div_bits  = W_BITS;
    div_den   = mul_r;
    div_lim   = WEIGHT_MAX;
    sq_start  = 1'b0;
    sq_x      = sq_r + mul_r;
    unique case (state_r)
      ivwa_pkg::S_SQ_RE:     begin mul_a = are;   mul_b = are;   end
      ivwa_pkg::S_SQ_IM:     begin mul_a = aim;   mul_b = aim;   end
      ivwa_pkg::S_MAG:       sq_start = 1'b1;
      ivwa_pkg::S_FLOOR_MUL: begin mul_a = mag_r; mul_b = {16'd0, error_floor_r}; end
      ivwa_pkg::S_ERR_MUL:   begin mul_a = err_r; mul_b = err_r; end
      ivwa_pkg::S_W_DIV:     div_start = 1'b1;
      ivwa_pkg::S_WR_HI:     begin mul_a = are;   mul_b = w_r[63:32]; end
      ivwa_pkg::S_WR_LO:     begin mul_a = are;   mul_b = w_r[31:0];  end
      ivwa_pkg::S_WR_P:      begin mul_a = aim;   mul_b = w_r[63:32]; end
      ivwa_pkg::S_WI_LO:     begin mul_a = aim;   mul_b = w_r[31:0];  end
      ivwa_pkg::S_T_DIV: begin
        div_start = 1'b1;
        div_den   = sw_r[idx];
        div_lim   = '1;
      end
      ivwa_pkg::S_T_SQRT: begin
        sq_start = 1'b1;
        sq_x     = div_quot;
      end
      ivwa_pkg::S_MRE_DIV: begin
        div_start = 1'b1;
        div_num   = abs_sre;
        div_bits  = M_BITS;
        div_den   = sw_r[idx];
        div_lim   = swre_r[idx][63] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      ivwa_pkg::S_MIM_DIV: begin
        div_start = 1'b1;
        div_num   = abs_sim;
        div_bits  = M_BITS;
        div_den   = sw_r[idx];
        div_lim   = swim_r[idx][63] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      default: ;
    endcase
  end

  // ---------------- datapath ----------------
  // weighted value: |v| * w >> F, saturated to the positive range, then signed
  always_comb begin
    wsum   = (hi_r << K) + (mul_r >> FRAC_BITS);
    wp     = (hi_r > HI_LIM || wsum[63]) ? INT64_MAX : wsum;
    wneg   = (state_r == ivwa_pkg::S_WR_P) ? re_r[31] : im_r[31];
    wv_nxt = wneg ? -$signed(wp) : $signed(wp);
    fl     = mul_r[47:16];
    fm     = (fl < {12'd0, absolute_min_r}) ? {12'd0, absolute_min_r} : fl;
    eff    = (err_r < fm) ? fm : err_r;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ivwa_pkg::S_IDLE: begin
        if (accept) begin
          comp_r <= in_data.component;
          last_r <= in_data.last_site;
          re_r   <= in_data.value_re;
          im_r   <= in_data.value_im;
          err_r  <= in_data.value_err;
        end
      end
      ivwa_pkg::S_SQ_IM:    sq_r <= mul_r;
      ivwa_pkg::S_MAG_WAIT: if (sq_stat.done) mag_r <= sq_root;
      ivwa_pkg::S_FLOOR:    err_r <= (eff == 32'd0) ? 32'd1 : eff;
      ivwa_pkg::S_W_WAIT:   if (div_stat.done) w_r <= div_quot;
      ivwa_pkg::S_WR_LO:    hi_r <= mul_r;
      ivwa_pkg::S_WR_P:     wv_r <= wv_nxt;
      ivwa_pkg::S_WI_LO:    hi_r <= mul_r;
      ivwa_pkg::S_WI_P:     wv_r <= wv_nxt;
      ivwa_pkg::S_CHK: begin
        avg_re_r  <= '0;
        avg_im_r  <= '0;
        avg_err_r <= '1;
      end
      ivwa_pkg::S_T_SQRT_WAIT: if (sq_stat.done) avg_err_r <= sq_root;
      ivwa_pkg::S_MRE_WAIT: begin
        if (div_stat.done) begin
          avg_re_r <= swre_r[idx][63] ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
        end
      end
      ivwa_pkg::S_MIM_WAIT: begin
        if (div_stat.done) begin
          avg_im_r <= swim_r[idx][63] ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
        end
      end
      default: ;
    endcase
  end

  // accumulator banks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        swre_r[i] <= '0;
        swim_r[i] <= '0;
        sw_r[i]   <= '0;
      end
    end else begin
      unique case (state_r)
        ivwa_pkg::S_WI_LO: swre_r[idx] <= sat_add(swre_r[idx], wv_r);
        ivwa_pkg::S_WI_ACC: begin
          swim_r[idx] <= sat_add(swim_r[idx], wv_r);
          sw_r[idx]   <= (sw_r[idx] > ~w_r) ? '1 : (sw_r[idx] + w_r);
        end
        ivwa_pkg::S_OUT: begin
          if (out_load) begin
            swre_r[idx] <= '0;
            swim_r[idx] <= '0;
            sw_r[idx]   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (out_load)       out_valid_r <= 1'b1;
    else if (!out_stall)     out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_component <= comp_r;
      out_data_r.avg_re        <= avg_re_r;
      out_data_r.avg_im        <= avg_im_r;
      out_data_r.avg_err       <= avg_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ivwa_pkg::S_OUT)
    else $error("result raised outside the output step");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_sqrt_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ivwa_pkg::S_WR_HI |-> w_r[63:62] == 2'b00)
    else $error("weight above saturation limit");

  a_bank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ivwa_pkg::S_WI_ACC |-> 32'(comp_r) < NUM_COMPONENTS)
    else $error("accumulation into a bank that does not exist");

endmodule
